### design/ctp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

	localparam int LINE_BYTES = 1024;
	localparam int KEY_LIMIT  = 16;

	// position counts up to LINE_BYTES itself; a token start stays below it
	localparam int POS_W   = $clog2(LINE_BYTES + 1);
	localparam int START_W = $clog2(LINE_BYTES);

	// token count saturates once no further comparison can tell it apart
	localparam int TN_CAP = (KEY_LIMIT + 2 > 7) ? KEY_LIMIT + 2 : 7;
	localparam int TN_W   = $clog2(TN_CAP + 1);

	localparam int OFF_W      = 10;
	localparam int LEN_W      = 11;
	localparam int NAME_BYTES = 8;
	localparam int NLEN_W     = 4;

	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] DIGIT_LO   = 8'h30;
	localparam logic [7:0] DIGIT_HI   = 8'h39;

	// token names packed first character in the low byte
	localparam logic [63:0] NM_SET     = 64'h0000_0000_0074_6573;
	localparam logic [63:0] NM_ADD     = 64'h0000_0000_0064_6461;
	localparam logic [63:0] NM_REPLACE = 64'h0065_6361_6c70_6572;
	localparam logic [63:0] NM_APPEND  = 64'h0000_646e_6570_7061;
	localparam logic [63:0] NM_PREPEND = 64'h0064_6e65_7065_7270;
	localparam logic [63:0] NM_CAS     = 64'h0000_0000_0073_6163;
	localparam logic [63:0] NM_GET     = 64'h0000_0000_0074_6567;
	localparam logic [63:0] NM_GETS    = 64'h0000_0000_7374_6567;
	localparam logic [63:0] NM_DELETE  = 64'h0000_6574_656c_6564;
	localparam logic [63:0] NM_INCR    = 64'h0000_0000_7263_6e69;
	localparam logic [63:0] NM_DECR    = 64'h0000_0000_7263_6564;
	localparam logic [63:0] NM_TOUCH   = 64'h0000_0068_6375_6f74;
	localparam logic [63:0] NM_STATS   = 64'h0000_0073_7461_7473;
	localparam logic [63:0] NM_QUIT    = 64'h0000_0000_7469_7571;
	localparam logic [63:0] NM_NOREPLY = 64'h0079_6c70_6572_6f6e;

	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_FLAGS = 2'd1,
		KIND_FINAL = 2'd2
	} kind_e;

	typedef enum logic [3:0] {
		CMD_SET     = 4'd0,
		CMD_ADD     = 4'd1,
		CMD_REPLACE = 4'd2,
		CMD_APPEND  = 4'd3,
		CMD_PREPEND = 4'd4,
		CMD_CAS     = 4'd5,
		CMD_GET     = 4'd6,
		CMD_GETS    = 4'd7,
		CMD_DELETE  = 4'd8,
		CMD_INCR    = 4'd9,
		CMD_DECR    = 4'd10,
		CMD_TOUCH   = 4'd11,
		CMD_STATS   = 4'd12,
		CMD_QUIT    = 4'd13,
		CMD_UNKNOWN = 4'd14
	} cmd_e;

	typedef enum logic [2:0] {
		CLS_STORE  = 3'd0,
		CLS_GET    = 3'd1,
		CLS_DELETE = 3'd2,
		CLS_CHANGE = 3'd3,
		CLS_STATS  = 3'd4,
		CLS_QUIT   = 3'd5,
		CLS_ERROR  = 3'd6
	} cls_e;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_NO_KEY    = 4'd1,
		ST_NO_FLAGS  = 4'd2,
		ST_NO_EXP    = 4'd3,
		ST_BAD_EXP   = 4'd4,
		ST_NO_LEN    = 4'd5,
		ST_BAD_LEN   = 4'd6,
		ST_NO_CAS    = 4'd7,
		ST_BAD_CAS   = 4'd8,
		ST_NO_VALUE  = 4'd9,
		ST_BAD_VALUE = 4'd10,
		ST_EXTRA     = 4'd11,
		ST_NO_KEYS   = 4'd12
	} st_e;

	typedef struct packed {
		kind_e              kind;
		cmd_e               word;
		cls_e               cls;
		st_e                status;
		logic [OFF_W-1:0]   offset;
		logic [LEN_W-1:0]   length;
		logic [31:0]        expiry;
		logic [31:0]        count;
		logic [63:0]        cas;
		logic [63:0]        change;
		logic               no_reply;
		logic               last;
	} rec_t;

	// which of the two record slots a byte fills
	typedef struct packed {
		logic a;
		logic b;
	} push_t;

	function automatic cls_e class_of(input cmd_e w);
		cls_e c;
		unique case (w)
			CMD_SET, CMD_ADD, CMD_REPLACE, CMD_APPEND, CMD_PREPEND, CMD_CAS: c = CLS_STORE;
			CMD_GET, CMD_GETS:                c = CLS_GET;
			CMD_DELETE:                       c = CLS_DELETE;
			CMD_INCR, CMD_DECR, CMD_TOUCH:    c = CLS_CHANGE;
			CMD_STATS:                        c = CLS_STATS;
			CMD_QUIT:                         c = CLS_QUIT;
			default:                          c = CLS_ERROR;
		endcase
		return c;
	endfunction

	function automatic cmd_e word_of(input logic [63:0] nbuf, input logic [NLEN_W-1:0] nlen);
		cmd_e w;
		w = CMD_UNKNOWN;
		if (nlen == 4'd3 && nbuf == NM_SET)     w = CMD_SET;
		if (nlen == 4'd3 && nbuf == NM_ADD)     w = CMD_ADD;
		if (nlen == 4'd7 && nbuf == NM_REPLACE) w = CMD_REPLACE;
		if (nlen == 4'd6 && nbuf == NM_APPEND)  w = CMD_APPEND;
		if (nlen == 4'd7 && nbuf == NM_PREPEND) w = CMD_PREPEND;
		if (nlen == 4'd3 && nbuf == NM_CAS)     w = CMD_CAS;
		if (nlen == 4'd3 && nbuf == NM_GET)     w = CMD_GET;
		if (nlen == 4'd4 && nbuf == NM_GETS)    w = CMD_GETS;
		if (nlen == 4'd6 && nbuf == NM_DELETE)  w = CMD_DELETE;
		if (nlen == 4'd4 && nbuf == NM_INCR)    w = CMD_INCR;
		if (nlen == 4'd4 && nbuf == NM_DECR)    w = CMD_DECR;
		if (nlen == 4'd5 && nbuf == NM_TOUCH)   w = CMD_TOUCH;
		if (nlen == 4'd5 && nbuf == NM_STATS)   w = CMD_STATS;
		if (nlen == 4'd4 && nbuf == NM_QUIT)    w = CMD_QUIT;
		return w;
	endfunction

endpackage

`default_nettype wire

### design/ctp_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module ctp_parse (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    data_byte_s1,
	input  wire logic          line_end_s1,
	output ctp_pkg::rec_t      rec_a,
	output ctp_pkg::rec_t      rec_b,
	output ctp_pkg::push_t     push
);
	import ctp_pkg::*;

	logic [POS_W-1:0]   pos_q, pos_d;
	logic [TN_W-1:0]    tnum_q, tnum_d;
	logic               intok_q, intok_d;
	logic [START_W-1:0] tstart_q, tstart_d;
	cmd_e               cmd_q, cmd_d;
	logic [63:0]        nbuf_q, nbuf_d;
	logic [NLEN_W-1:0]  nlen_q, nlen_d;
	logic [63:0]        acc_q, acc_d;
	logic               bad_q, bad_d;
	st_e                st_q, st_d;
	logic [31:0]        exp_q, exp_d;
	logic [31:0]        blen_q, blen_d;
	logic [63:0]        cas_q, cas_d;
	logic [63:0]        chg_q, chg_d;
	logic               nrep_q, nrep_d;

	logic               do_close;
	logic [POS_W-1:0]   close_at;
	logic [POS_W-1:0]   tlen;
	cls_e               tok_cls;
	logic [TN_W-1:0]    opt_at;
	logic               checked;
	logic [67:0]        acc_wide;
	logic [31:0]        acc_sat;
	st_e                st_fin;
	cmd_e               word_fin;

	always_comb begin
		pos_d    = pos_q;
		tnum_d   = tnum_q;
		intok_d  = intok_q;
		tstart_d = tstart_q;
		cmd_d    = cmd_q;
		nbuf_d   = nbuf_q;
		nlen_d   = nlen_q;
		acc_d    = acc_q;
		bad_d    = bad_q;
		st_d     = st_q;
		exp_d    = exp_q;
		blen_d   = blen_q;
		cas_d    = cas_q;
		chg_d    = chg_q;
		nrep_d   = nrep_q;
		do_close = 1'b0;
		close_at = pos_q;
		acc_wide = '0;

		// bytes past the line limit are dropped
		if (pos_q < POS_W'(LINE_BYTES)) begin
			if (data_byte_s1 != SPACE_BYTE) begin
				if (!intok_q) begin
					intok_d  = 1'b1;
					tstart_d = START_W'(pos_q);
					nbuf_d   = '0;
					nlen_d   = '0;
					acc_d    = '0;
					bad_d    = 1'b0;
				end
				if (nlen_d < NLEN_W'(NAME_BYTES)) begin
					for (int k = 0; k < NAME_BYTES; k++) begin
						if (nlen_d == NLEN_W'(k)) nbuf_d[8*k +: 8] = data_byte_s1;
					end
					nlen_d = nlen_d + NLEN_W'(1);
				end
				if (data_byte_s1 >= DIGIT_LO && data_byte_s1 <= DIGIT_HI) begin
					acc_wide = ({4'b0, acc_d} << 3) + ({4'b0, acc_d} << 1)
						+ 68'(data_byte_s1 - DIGIT_LO);
					acc_d = (acc_wide[67:64] != 4'd0) ? '1 : acc_wide[63:0];
				end else begin
					bad_d = 1'b1;
				end
			end else if (intok_q) begin
				do_close = 1'b1;
				close_at = pos_q;
				intok_d  = 1'b0;
			end
			pos_d = pos_q + POS_W'(1);
		end

		// a token still open at the last byte ends here
		if (line_end_s1 && intok_d) begin
			do_close = 1'b1;
			close_at = pos_d;
			intok_d  = 1'b0;
		end
	end

	always_comb begin
		tok_cls = class_of(cmd_q);
		checked = 1'b1;
		opt_at  = '0;
		unique case (tok_cls)
			CLS_STORE:  opt_at = (cmd_q == CMD_CAS) ? TN_W'(6) : TN_W'(5);
			CLS_CHANGE: opt_at = TN_W'(3);
			CLS_DELETE: opt_at = TN_W'(2);
			CLS_GET:    opt_at = TN_W'(KEY_LIMIT + 1);
			default:    checked = 1'b0;
		endcase
	end

	assign tlen    = close_at - POS_W'(tstart_d);
	assign acc_sat = (acc_d[63:32] != 32'd0) ? '1 : acc_d[31:0];

	// token close, then line close, on the pre-close values
	logic [TN_W-1:0] tnum_c;
	cmd_e            cmd_c;
	st_e             st_c;
	logic [31:0]     exp_c, blen_c;
	logic [63:0]     cas_c, chg_c;
	logic            nrep_c;
	logic            tok_rec;
	kind_e           tok_kind;

	always_comb begin
		tnum_c   = tnum_d;
		cmd_c    = cmd_d;
		st_c     = st_d;
		exp_c    = exp_d;
		blen_c   = blen_d;
		cas_c    = cas_d;
		chg_c    = chg_d;
		nrep_c   = nrep_d;
		tok_rec  = 1'b0;
		tok_kind = KIND_KEY;
		if (do_close) begin
			if (tnum_q < TN_W'(TN_CAP)) tnum_c = tnum_q + TN_W'(1);
			if (tnum_q == '0) begin
				cmd_c = word_of(nbuf_d, nlen_d);
			end else if (checked) begin
				if (tnum_q == TN_W'(1) || (tok_cls == CLS_GET && tnum_q <= TN_W'(KEY_LIMIT))) begin
					tok_rec = 1'b1;
				end else if (tnum_q == opt_at) begin
					if (st_q == ST_OK) begin
						if (nlen_d == 4'd7 && nbuf_d == NM_NOREPLY) nrep_c = 1'b1;
						else st_c = ST_EXTRA;
					end
				end else if (tok_cls == CLS_STORE) begin
					if (tnum_q == TN_W'(2)) begin
						tok_rec  = 1'b1;
						tok_kind = KIND_FLAGS;
					end else if (st_q == ST_OK && tnum_q == TN_W'(3)) begin
						if (bad_d) st_c = ST_BAD_EXP; else exp_c = acc_sat;
					end else if (st_q == ST_OK && tnum_q == TN_W'(4)) begin
						if (bad_d) st_c = ST_BAD_LEN; else blen_c = acc_sat;
					end else if (st_q == ST_OK && tnum_q == TN_W'(5)) begin
						if (bad_d) st_c = ST_BAD_CAS; else cas_c = acc_d;
					end
				end else if (tok_cls == CLS_CHANGE && st_q == ST_OK && tnum_q == TN_W'(2)) begin
					if (bad_d) st_c = ST_BAD_VALUE; else chg_c = acc_d;
				end
			end
		end
	end

	// missing-token checks for the final record
	always_comb begin
		st_fin   = st_c;
		word_fin = (tnum_c == '0) ? CMD_UNKNOWN : cmd_c;
		if (st_c == ST_OK && tnum_c != '0) begin
			unique case (class_of(cmd_c))
				CLS_STORE: begin
					if (tnum_c == TN_W'(1))      st_fin = ST_NO_KEY;
					else if (tnum_c == TN_W'(2)) st_fin = ST_NO_FLAGS;
					else if (tnum_c == TN_W'(3)) st_fin = ST_NO_EXP;
					else if (tnum_c == TN_W'(4)) st_fin = ST_NO_LEN;
					else if (tnum_c == TN_W'(5) && cmd_c == CMD_CAS) st_fin = ST_NO_CAS;
				end
				CLS_CHANGE: begin
					if (tnum_c == TN_W'(1))      st_fin = ST_NO_KEY;
					else if (tnum_c == TN_W'(2)) st_fin = ST_NO_VALUE;
				end
				CLS_GET: begin
					if (tnum_c == TN_W'(1)) st_fin = ST_NO_KEYS;
				end
				CLS_DELETE: begin
					if (tnum_c == TN_W'(1)) st_fin = ST_NO_KEY;
				end
				default: st_fin = st_c;
			endcase
		end
	end

	always_comb begin
		rec_a        = '0;
		rec_a.kind   = tok_kind;
		rec_a.word   = cmd_q;
		rec_a.cls    = tok_cls;
		rec_a.status = st_q;
		rec_a.offset = OFF_W'(tstart_d);
		rec_a.length = LEN_W'(tlen);

		rec_b          = '0;
		rec_b.kind     = KIND_FINAL;
		rec_b.word     = word_fin;
		rec_b.cls      = class_of(word_fin);
		rec_b.status   = st_fin;
		rec_b.expiry   = exp_c;
		rec_b.count    = blen_c;
		rec_b.cas      = cas_c;
		rec_b.change   = chg_c;
		rec_b.no_reply = nrep_c;
		rec_b.last     = 1'b1;

		push.a = tok_rec;
		push.b = line_end_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			tnum_q   <= '0;
			intok_q  <= 1'b0;
			tstart_q <= '0;
			cmd_q    <= CMD_SET;
			nbuf_q   <= '0;
			nlen_q   <= '0;
			acc_q    <= '0;
			bad_q    <= 1'b0;
			st_q     <= ST_OK;
			exp_q    <= '0;
			blen_q   <= '0;
			cas_q    <= '0;
			chg_q    <= '0;
			nrep_q   <= 1'b0;
		end else if (step) begin
			if (line_end_s1) begin
				// back to the reset picture for the next line
				pos_q    <= '0;
				tnum_q   <= '0;
				intok_q  <= 1'b0;
				tstart_q <= '0;
				cmd_q    <= CMD_SET;
				nbuf_q   <= '0;
				nlen_q   <= '0;
				acc_q    <= '0;
				bad_q    <= 1'b0;
				st_q     <= ST_OK;
				exp_q    <= '0;
				blen_q   <= '0;
				cas_q    <= '0;
				chg_q    <= '0;
				nrep_q   <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				tnum_q   <= tnum_c;
				intok_q  <= intok_d;
				tstart_q <= tstart_d;
				cmd_q    <= cmd_c;
				nbuf_q   <= nbuf_d;
				nlen_q   <= nlen_d;
				acc_q    <= acc_d;
				bad_q    <= bad_d;
				st_q     <= st_c;
				exp_q    <= exp_c;
				blen_q   <= blen_c;
				cas_q    <= cas_c;
				chg_q    <= chg_c;
				nrep_q   <= nrep_c;
			end
		end
	end

`ifndef SYNTHESIS
	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && line_end_s1 |=> pos_q == '0 && tnum_q == '0 && !intok_q)
		else $error("line state not cleared after final byte");
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(LINE_BYTES))
		else $error("byte position ran past the line limit");
`endif

endmodule

`default_nettype wire

### design/ctp_rec_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ctp_rec_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  ctp_pkg::push_t      push,
	input  ctp_pkg::rec_t       rec_a,
	input  ctp_pkg::rec_t       rec_b,
	input  wire logic           out_stall,
	output logic                out_valid,
	output ctp_pkg::rec_t       head,
	output logic [1:0]          room
);
	import ctp_pkg::*;

	rec_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] n_push;
	rec_t       first;

	assign out_valid = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];
	assign pop       = out_valid && !out_stall;
	assign n_push    = {1'b0, push.a} + {1'b0, push.b};
	assign first     = push.a ? rec_a : rec_b;
	// a slot freed by this beat's pop counts as room
	assign room      = 2'd2 - cnt_q + {1'b0, pop};

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) mem_q[wr_q] <= first;
		if (push.a && push.b) mem_q[~wr_q] <= rec_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			wr_q  <= wr_q ^ n_push[0];
			rd_q  <= rd_q ^ pop;
			cnt_q <= cnt_q + n_push - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("record queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !pop |-> !push.a && !push.b)
		else $error("record pushed into a full queue");
`endif

endmodule

`default_nettype wire

### design/cache_text_command_parser_top.sv
// Parses one text cache command line, one byte per input beat, and emits a record for each
// key and flags token plus a final record that summarises the line on its last byte. A byte
// is registered on acceptance and parsed from that register straight into a two-entry
// record queue, which registers the records again before the output; one byte is taken every
// cycle while the output keeps up. The last byte of a line that also closes a key or flags
// token yields two records; the queue depth sets how far input runs ahead of a stalled
// output. All parse state returns to reset after each final record.
`timescale 1ns / 1ps
`default_nettype none

module cache_text_command_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        line_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       record_kind,
	output logic [3:0]       command_word,
	output logic [2:0]       command_class,
	output logic [3:0]       line_status,
	output logic [9:0]       token_offset,
	output logic [10:0]      token_length,
	output logic [31:0]      expiry_time,
	output logic [31:0]      byte_count,
	output logic [63:0]      cas_unique,
	output logic [63:0]      change_value,
	output logic             no_reply,
	output logic             last
);
	import ctp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       line_end_s1;
	logic       advance;
	logic       in_take;
	logic [1:0] need;
	logic [1:0] room;
	rec_t       rec_a, rec_b, head;
	push_t      push, push_g;

	ctp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data_byte_s1 (data_byte_s1),
		.line_end_s1  (line_end_s1),
		.rec_a        (rec_a),
		.rec_b        (rec_b),
		.push         (push)
	);

	assign need    = {1'b0, push.a} + {1'b0, push.b};
	assign advance = valid_s1 && (need <= room);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		push_g.a = push.a && advance;
		push_g.b = push.b && advance;
	end

	ctp_rec_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_g),
		.rec_a     (rec_a),
		.rec_b     (rec_b),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.room      (room)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_byte_s1 <= data_byte;
			line_end_s1  <= line_end;
		end
	end

	assign record_kind   = head.kind;
	assign command_word  = head.word;
	assign command_class = head.cls;
	assign line_status   = head.status;
	assign token_offset  = head.offset;
	assign token_length  = head.length;
	assign expiry_time   = head.expiry;
	assign byte_count    = head.count;
	assign cas_unique    = head.cas;
	assign change_value  = head.change;
	assign no_reply      = head.no_reply;
	assign last          = head.last;

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ctp_pkg::*;

	localparam int IDLE_LIMIT  = 1000;
	localparam int TAIL_CYCLES = 12;
	localparam int RANDOM_BYTES = 1050;

	typedef struct {
		string text;
		int    pad;
		bit    pinned;
		cmd_e  word;
		cls_e  cls;
		st_e   st;
	} row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        line_end  = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  record_kind;
	logic [3:0]  command_word;
	logic [2:0]  command_class;
	logic [3:0]  line_status;
	logic [9:0]  token_offset;
	logic [10:0] token_length;
	logic [31:0] expiry_time;
	logic [31:0] byte_count;
	logic [63:0] cas_unique;
	logic [63:0] change_value;
	logic        no_reply;
	logic        last;

	cache_text_command_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .line_end(line_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.record_kind(record_kind), .command_word(command_word),
		.command_class(command_class), .line_status(line_status),
		.token_offset(token_offset), .token_length(token_length),
		.expiry_time(expiry_time), .byte_count(byte_count),
		.cas_unique(cas_unique), .change_value(change_value),
		.no_reply(no_reply), .last(last)
	);

	initial forever #5 clk = ~clk;

	// line parser state, mirrored beat by beat
	int          byte_pos;
	int          tok_no;
	bit          in_tok;
	int          tok_start;
	cmd_e        cur_cmd;
	logic [63:0] name_buf;
	int          name_len;
	logic [63:0] num_acc;
	bit          num_bad;
	st_e         cur_status;
	logic [31:0] exp_val;
	logic [31:0] cnt_val;
	logic [63:0] cas_val;
	logic [63:0] chg_val;
	bit          noreply_seen;

	rec_t pending_records[$];
	rec_t want;

	int beats_in;
	int recs_out;
	int idle_cycles;
	int bad_count;
	int lines_sent;
	int bytes_sent;

	bit   pin_on;
	cmd_e pin_word;
	cls_e pin_cls;
	st_e  pin_st;
	bit   calm;

	logic [7:0] line_bytes[$];
	int         toks;
	int         keep;
	row_t       plan[$];

	function automatic cls_e group_of(cmd_e w);
		case (w)
			CMD_SET, CMD_ADD, CMD_REPLACE, CMD_APPEND, CMD_PREPEND, CMD_CAS: return CLS_STORE;
			CMD_GET, CMD_GETS:             return CLS_GET;
			CMD_DELETE:                    return CLS_DELETE;
			CMD_INCR, CMD_DECR, CMD_TOUCH: return CLS_CHANGE;
			CMD_STATS:                     return CLS_STATS;
			CMD_QUIT:                      return CLS_QUIT;
			default:                       return CLS_ERROR;
		endcase
	endfunction

	function automatic string word_text(cmd_e w);
		case (w)
			CMD_SET:     return "set";
			CMD_ADD:     return "add";
			CMD_REPLACE: return "replace";
			CMD_APPEND:  return "append";
			CMD_PREPEND: return "prepend";
			CMD_CAS:     return "cas";
			CMD_GET:     return "get";
			CMD_GETS:    return "gets";
			CMD_DELETE:  return "delete";
			CMD_INCR:    return "incr";
			CMD_DECR:    return "decr";
			CMD_TOUCH:   return "touch";
			CMD_STATS:   return "stats";
			CMD_QUIT:    return "quit";
			default:     return "";
		endcase
	endfunction

	function automatic bit name_eq(string s);
		int k;
		if (s.len() != name_len) return 1'b0;
		for (k = 0; k < s.len(); k++)
			if (name_buf[8*k +: 8] != s[k]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] clamp32(logic [63:0] v);
		return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic void clear_line_state();
		byte_pos = 0; tok_no = 0; in_tok = 1'b0; tok_start = 0;
		cur_cmd = CMD_SET; name_buf = '0; name_len = 0; num_acc = '0;
		num_bad = 1'b0; cur_status = ST_OK; exp_val = '0; cnt_val = '0;
		cas_val = '0; chg_val = '0; noreply_seen = 1'b0;
	endfunction

	function automatic rec_t line_rec(kind_e k, int off, int len, bit fin);
		rec_t r;
		cmd_e w;
		w = (tok_no == 0) ? CMD_UNKNOWN : cur_cmd;
		r.kind     = k;
		r.word     = w;
		r.cls      = group_of(w);
		r.status   = cur_status;
		r.offset   = off[OFF_W-1:0];
		r.length   = len[LEN_W-1:0];
		r.expiry   = fin ? exp_val : '0;
		r.count    = fin ? cnt_val : '0;
		r.cas      = fin ? cas_val : '0;
		r.change   = fin ? chg_val : '0;
		r.no_reply = fin & noreply_seen;
		r.last     = fin;
		return r;
	endfunction

	function automatic void end_token(int stop);
		int   tn;
		int   opt;
		int   w;
		bit   ok;
		cls_e g;
		tn = tok_no;
		g = group_of(cur_cmd);
		ok = (cur_status == ST_OK);
		opt = 0;
		in_tok = 1'b0;
		if (tok_no < 255) tok_no++;
		if (tn == 0) begin
			cur_cmd = CMD_UNKNOWN;
			for (w = 0; w < 14; w++)
				if (cur_cmd == CMD_UNKNOWN && name_eq(word_text(cmd_e'(w)))) cur_cmd = cmd_e'(w);
			return;
		end
		case (g)
			CLS_STORE:  opt = (cur_cmd == CMD_CAS) ? 6 : 5;
			CLS_CHANGE: opt = 3;
			CLS_DELETE: opt = 2;
			CLS_GET:    opt = KEY_LIMIT + 1;
			default:    return;
		endcase
		if (tn == 1 || (g == CLS_GET && tn <= KEY_LIMIT)) begin
			pending_records.push_back(line_rec(KIND_KEY, tok_start, stop - tok_start, 1'b0));
		end else if (tn == opt) begin
			if (ok) begin
				if (name_eq("noreply")) noreply_seen = 1'b1;
				else cur_status = ST_EXTRA;
			end
		end else if (g == CLS_STORE) begin
			if (tn == 2) begin
				pending_records.push_back(line_rec(KIND_FLAGS, tok_start, stop - tok_start, 1'b0));
			end else if (ok && tn == 3) begin
				if (num_bad) cur_status = ST_BAD_EXP; else exp_val = clamp32(num_acc);
			end else if (ok && tn == 4) begin
				if (num_bad) cur_status = ST_BAD_LEN; else cnt_val = clamp32(num_acc);
			end else if (ok && tn == 5) begin
				if (num_bad) cur_status = ST_BAD_CAS; else cas_val = num_acc;
			end
		end else if (g == CLS_CHANGE && ok && tn == 2) begin
			if (num_bad) cur_status = ST_BAD_VALUE; else chg_val = num_acc;
		end
	endfunction

	function automatic void parse_byte(logic [7:0] c, logic eol);
		logic [63:0] d;
		cls_e        g;
		if (byte_pos < LINE_BYTES) begin
			if (c != SPACE_BYTE) begin
				if (!in_tok) begin
					in_tok = 1'b1; tok_start = byte_pos;
					name_buf = '0; name_len = 0; num_acc = '0; num_bad = 1'b0;
				end
				if (name_len < 8) begin
					name_buf[8*name_len +: 8] = c;
					name_len++;
				end
				if (c >= DIGIT_LO && c <= DIGIT_HI) begin
					d = {56'd0, c - DIGIT_LO};
					if (num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) num_acc = '1;
					else num_acc = num_acc * 64'd10 + d;
				end else begin
					num_bad = 1'b1;
				end
			end else if (in_tok) begin
				end_token(byte_pos);
			end
			byte_pos++;
		end
		if (eol) begin
			if (in_tok) end_token(byte_pos);
			g = (tok_no == 0) ? CLS_ERROR : group_of(cur_cmd);
			// missing fields are only judged when nothing failed earlier
			if (cur_status == ST_OK && tok_no > 0) begin
				case (g)
					CLS_STORE: begin
						if (tok_no == 1) cur_status = ST_NO_KEY;
						else if (tok_no == 2) cur_status = ST_NO_FLAGS;
						else if (tok_no == 3) cur_status = ST_NO_EXP;
						else if (tok_no == 4) cur_status = ST_NO_LEN;
						else if (tok_no == 5 && cur_cmd == CMD_CAS) cur_status = ST_NO_CAS;
					end
					CLS_CHANGE: begin
						if (tok_no == 1) cur_status = ST_NO_KEY;
						else if (tok_no == 2) cur_status = ST_NO_VALUE;
					end
					CLS_GET:    if (tok_no == 1) cur_status = ST_NO_KEYS;
					CLS_DELETE: if (tok_no == 1) cur_status = ST_NO_KEY;
					default: ;
				endcase
			end
			pending_records.push_back(line_rec(KIND_FINAL, 0, 0, 1'b1));
			clear_line_state();
		end
	endfunction

	function automatic void chk(string field, logic [63:0] exp_v, logic [63:0] got);
		if (exp_v !== got) begin
			$error("%s: expected %0h, got %0h", field, exp_v, got);
			bad_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_line_state();
		end else begin
			if (in_valid && !in_stall) begin
				beats_in++;
				parse_byte(data_byte, line_end);
				// hand-typed outcome of a directed line overrides the predicted one
				if (pin_on && line_end) begin
					pending_records[pending_records.size()-1].word   = pin_word;
					pending_records[pending_records.size()-1].cls    = pin_cls;
					pending_records[pending_records.size()-1].status = pin_st;
				end
			end
			if (out_valid && !out_stall) begin
				recs_out++;
				if (pending_records.size() == 0) begin
					$error("record_kind: expected no record, got %0d", record_kind);
					bad_count++;
				end else begin
					want = pending_records.pop_front();
					chk("record_kind", want.kind, record_kind);
					chk("command_word", want.word, command_word);
					chk("command_class", want.cls, command_class);
					chk("line_status", want.status, line_status);
					chk("token_offset", want.offset, token_offset);
					chk("token_length", want.length, token_length);
					chk("expiry_time", want.expiry, expiry_time);
					chk("byte_count", want.count, byte_count);
					chk("cas_unique", want.cas, cas_unique);
					chk("change_value", want.change, change_value);
					chk("no_reply", want.no_reply, no_reply);
					chk("last", want.last, last);
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	function automatic int idle_len();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	// any byte but a space
	function automatic logic [7:0] tok_char();
		logic [7:0] b;
		b = 8'($urandom_range(0, 254));
		if (b >= SPACE_BYTE) b = b + 8'd1;
		return b;
	endfunction

	function automatic void put_spaces();
		repeat ($urandom_range(1, 3)) line_bytes.push_back(SPACE_BYTE);
	endfunction

	function automatic bit open_token();
		if (toks >= keep) return 1'b0;
		if (toks > 0) put_spaces();
		toks++;
		return 1'b1;
	endfunction

	function automatic void put_word(string s);
		int i;
		if (!open_token()) return;
		for (i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
	endfunction

	function automatic void put_key();
		int n;
		if (!open_token()) return;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
		repeat (n) line_bytes.push_back(tok_char());
	endfunction

	function automatic void put_number();
		int         n;
		int         i;
		int         r;
		int         bad_at;
		logic [7:0] b;
		if (!open_token()) return;
		r = $urandom_range(0, 7);
		n = (r == 0) ? $urandom_range(20, 24) : (r == 1) ? $urandom_range(9, 12)
			: $urandom_range(1, 4);
		bad_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
		for (i = 0; i < n; i++) begin
			if (i == bad_at) begin
				do b = tok_char(); while (b >= DIGIT_LO && b <= DIGIT_HI);
			end else begin
				b = DIGIT_LO + 8'($urandom_range(0, 9));
			end
			line_bytes.push_back(b);
		end
	endfunction

	function automatic void build_random_line();
		cmd_e c;
		line_bytes.delete();
		toks = 0;
		// cut some lines short to reach the missing-field errors
		keep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 1000;
		if ($urandom_range(0, 3) == 0) put_spaces();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 24))
				line_bytes.push_back(($urandom_range(0, 3) == 0) ? SPACE_BYTE
					: 8'($urandom_range(0, 255)));
			return;
		end
		c = cmd_e'($urandom_range(0, 14));
		if (c == CMD_UNKNOWN) put_key(); else put_word(word_text(c));
		case (group_of(c))
			CLS_STORE: begin
				put_key(); put_key(); put_number(); put_number();
				if (c == CMD_CAS) put_number();
			end
			CLS_CHANGE: begin
				put_key(); put_number();
			end
			CLS_DELETE: put_key();
			CLS_GET:    repeat ($urandom_range(1, KEY_LIMIT + 2)) put_key();
			default:    repeat ($urandom_range(0, 3)) put_key();
		endcase
		if ($urandom_range(0, 2) == 0) put_word("noreply");
		if ($urandom_range(0, 5) == 0) put_key();
		if ($urandom_range(0, 3) == 0) put_spaces();
		if (line_bytes.size() == 0) line_bytes.push_back(SPACE_BYTE);
	endfunction

	task automatic send_line();
		int i;
		int gap;
		int seen;
		for (i = 0; i < line_bytes.size(); i++) begin
			gap = idle_len();
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid  = 1'b1;
			data_byte = line_bytes[i];
			line_end  = (i == line_bytes.size() - 1);
			seen = beats_in;
			do @(negedge clk); while (beats_in == seen);
		end
		lines_sent++;
		bytes_sent += line_bytes.size();
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending_records.size() != 0) @(negedge clk);
	endtask

	initial begin
		int n;
		int seen;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = idle_len();
			if (n > 0) begin
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall = 1'b0;
			seen = recs_out;
			do @(negedge clk); while (recs_out == seen);
		end
	end

	initial begin
		int i;
		plan.push_back(row_t'{" ", 0, 1'b1, CMD_UNKNOWN, CLS_ERROR, ST_OK});
		plan.push_back(row_t'{"set k 0 0 5", 0, 1'b1, CMD_SET, CLS_STORE, ST_OK});
		plan.push_back(row_t'{"add key 4294967295 99999999999999999999999 4294967296 noreply",
			0, 1'b1, CMD_ADD, CLS_STORE, ST_OK});
		plan.push_back(row_t'{"replace k f", 0, 1'b1, CMD_REPLACE, CLS_STORE, ST_NO_EXP});
		plan.push_back(row_t'{"append k f 1", 0, 1'b1, CMD_APPEND, CLS_STORE, ST_NO_LEN});
		plan.push_back(row_t'{"prepend k f -1 5", 0, 1'b1, CMD_PREPEND, CLS_STORE, ST_BAD_EXP});
		plan.push_back(row_t'{"set k f 1 +5", 0, 1'b1, CMD_SET, CLS_STORE, ST_BAD_LEN});
		plan.push_back(row_t'{"cas k f 1 2", 0, 1'b1, CMD_CAS, CLS_STORE, ST_NO_CAS});
		plan.push_back(row_t'{"cas k f 1 2 x3", 0, 1'b1, CMD_CAS, CLS_STORE, ST_BAD_CAS});
		plan.push_back(row_t'{"cas k f 0 18446744073709551615 18446744073709551616 noreply",
			0, 1'b0, CMD_CAS, CLS_STORE, ST_OK});
		plan.push_back(row_t'{"set k", 0, 1'b1, CMD_SET, CLS_STORE, ST_NO_FLAGS});
		plan.push_back(row_t'{"set", 0, 1'b1, CMD_SET, CLS_STORE, ST_NO_KEY});
		plan.push_back(row_t'{"incr k", 0, 1'b1, CMD_INCR, CLS_CHANGE, ST_NO_VALUE});
		plan.push_back(row_t'{"decr k 1a", 0, 1'b1, CMD_DECR, CLS_CHANGE, ST_BAD_VALUE});
		plan.push_back(row_t'{"touch k 18446744073709551616 noreply",
			0, 1'b0, CMD_TOUCH, CLS_CHANGE, ST_OK});
		plan.push_back(row_t'{"incr k 5 junk", 0, 1'b1, CMD_INCR, CLS_CHANGE, ST_EXTRA});
		plan.push_back(row_t'{"delete k noreply extra tokens", 0, 1'b0, CMD_DELETE, CLS_DELETE, ST_OK});
		plan.push_back(row_t'{"delete", 0, 1'b1, CMD_DELETE, CLS_DELETE, ST_NO_KEY});
		plan.push_back(row_t'{"get", 0, 1'b1, CMD_GET, CLS_GET, ST_NO_KEYS});
		plan.push_back(row_t'{"gets a b c d e f g h i j k l m n o p noreply",
			0, 1'b0, CMD_GETS, CLS_GET, ST_OK});
		// a full set of keys and then one more
		plan.push_back(row_t'{"gets a b c d e f g h i j k l m n o p q",
			0, 1'b1, CMD_GETS, CLS_GET, ST_EXTRA});
		// noreply among the keys is just another key
		plan.push_back(row_t'{"get noreply x", 0, 1'b0, CMD_GET, CLS_GET, ST_OK});
		plan.push_back(row_t'{"  stats  detail x ", 0, 1'b1, CMD_STATS, CLS_STATS, ST_OK});
		plan.push_back(row_t'{"quit", 0, 1'b1, CMD_QUIT, CLS_QUIT, ST_OK});
		plan.push_back(row_t'{"QUIT", 0, 1'b1, CMD_UNKNOWN, CLS_ERROR, ST_OK});
		plan.push_back(row_t'{"replacement k 1", 0, 1'b1, CMD_UNKNOWN, CLS_ERROR, ST_OK});
		// key runs past the line buffer and is cut there
		plan.push_back(row_t'{"get ", 1030, 1'b1, CMD_GET, CLS_GET, ST_OK});

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[r]) begin
			line_bytes.delete();
			for (i = 0; i < plan[r].text.len(); i++) line_bytes.push_back(plan[r].text[i]);
			repeat (plan[r].pad) line_bytes.push_back("k");
			pin_on   = plan[r].pinned;
			pin_word = plan[r].word;
			pin_cls  = plan[r].cls;
			pin_st   = plan[r].st;
			calm     = (r % 4 == 0);
			send_line();
		end
		pin_on = 1'b0;
		drain();

		while (bytes_sent < plan.size() * 0 + RANDOM_BYTES + 1100) begin
			build_random_line();
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 15) == 0) drain();
			send_line();
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Sent %0d lines, %0d bytes: all commands, every status, saturation, long line",
			lines_sent, bytes_sent);
		$display("Compared %0d records with the line predictor, %0d mismatches",
			recs_out, bad_count);
		if (bad_count == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule
